>>> hdl/multiset_bag_table_unit_macros.svh
// ---------------------------------------------------------------------------
// multiset bag table assertion macros
// concurrent assertion helpers clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef MULTISET_BAG_TABLE_UNIT_MACROS_SVH
`define MULTISET_BAG_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MBT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbt assertion failed in same cycle");
`define MBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbt assertion failed in next cycle");
`else
`define MBT_ASSERT_SAME(lbl, ante, cons)
`define MBT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/mbt_pkg.sv
// ---------------------------------------------------------------------------
// mbt_pkg
// shared types and constants of the multiset bag table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbt_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } state_t;

endpackage

`default_nettype wire

>>> hdl/mbt_ram.sv
// ---------------------------------------------------------------------------
// mbt_ram
// generic single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/multiset_bag_table_unit.sv
// ---------------------------------------------------------------------------
// multiset_bag_table_unit
// unordered multiset of up to CAPACITY values, packed in a ram with a count
// ---------------------------------------------------------------------------
// usage:
//   raise start with in_func and in_item_value while busy is low; the item
//   transfers at that clock edge. add appends, remove deletes the first equal
//   entry and closes the gap, query counts equal entries, clear empties.
//   one result per item appears on the out_ ports for exactly one cycle,
//   marked by out_strobe; the receiver cannot stall it.
// operation:
//   add and clear: result in the cycle after the transfer, busy never rises.
//   query: all stored entries are scanned, one stored entry per cycle through a
//   single comparator fed by the ram's registered read port.
//   remove: scan up to the first match, then shift each entry above it down
//   one slot and drop the count by one; without a match the whole fill is
//   scanned and the count stays.
//   busy is high for the whole scan/shift; a new item may transfer in the
//   cycle the result is shown.
// reset:
//   synchronous active-low rst_n empties the table (count to zero); the ram
//   contents are left alone; entries at or above the count are never used.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multiset_bag_table_unit #(
  parameter int CAPACITY   = mbt_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = mbt_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mbt_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [mbt_pkg::VALUE_W-1:0]   in_item_value,
  output logic                               out_strobe,
  output logic                               out_ok,
  output logic      [mbt_pkg::COUNT_W-1:0]   out_match_count,
  output logic                               out_present,
  output logic      [mbt_pkg::COUNT_W-1:0]   out_fill_count,
  output logic                               out_is_empty
);

  import mbt_pkg::*;

`include "multiset_bag_table_unit_macros.svh"

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  // state
  state_t                state_r, state_nxt;
  func_t                 op_r, op_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]         cmp_idx_r, cmp_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [CW-1:0]         wr_idx_r, wr_idx_nxt;
  logic [CW-1:0]         match_r, match_nxt;

  // result registers
  logic                  strobe_r, strobe_nxt;
  logic                  ok_r, ok_nxt;
  logic [CW-1:0]         res_match_r, res_match_nxt;
  logic                  present_r, present_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;

  // ram port
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [DATA_WIDTH+VALUE_W-1:0] in_val_ext;
  logic [DATA_WIDTH-1:0]         in_val;
  logic                          hit;
  logic [CW+COUNT_W-1:0]         match_ext;
  logic [CW+COUNT_W-1:0]         fill_ext;

  assign in_val_ext = {{DATA_WIDTH{1'b0}}, in_item_value};
  assign in_val     = in_val_ext[DATA_WIDTH-1:0];

  // the one shared comparator
  assign hit = cmp_vld_r && (ram_rdata == val_r);

  mbt_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx_r[IW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    val_r       <= val_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    cmp_vld_r   <= cmp_vld_nxt;
    wr_idx_r    <= wr_idx_nxt;
    match_r     <= match_nxt;
    ok_r        <= ok_nxt;
    res_match_r <= res_match_nxt;
    present_r   <= present_nxt;
    fill_r      <= fill_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = 1'b0;
    wr_idx_nxt    = wr_idx_r;
    match_nxt     = match_r;
    strobe_nxt    = 1'b0;
    ok_nxt        = ok_r;
    res_match_nxt = res_match_r;
    present_nxt   = present_r;
    fill_nxt      = fill_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[IW-1:0];
    ram_wdata     = in_val;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt        = func_t'(in_func);
          val_nxt       = in_val;
          rd_idx_nxt    = '0;
          match_nxt     = '0;
          res_match_nxt = '0;
          present_nxt   = 1'b0;
          ok_nxt        = 1'b1;
          case (func_t'(in_func))
            OP_ADD: begin
              strobe_nxt = 1'b1;
              if (cnt_r < CW'(CAPACITY)) begin
                ram_we   = 1'b1;
                cnt_nxt  = cnt_r + 1'b1;
                fill_nxt = cnt_r + 1'b1;
              end else begin
                ok_nxt   = 1'b0;
                fill_nxt = cnt_r;
              end
            end
            OP_CLEAR: begin
              strobe_nxt = 1'b1;
              cnt_nxt    = '0;
              fill_nxt   = '0;
            end
            default: begin
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // each compare runs in the cycle after its read is issued
        if (rd_idx_r < cnt_r) begin
          rd_idx_nxt  = rd_idx_r + 1'b1;
          cmp_idx_nxt = rd_idx_r;
          cmp_vld_nxt = 1'b1;
        end
        if (hit) begin
          match_nxt = match_r + 1'b1;
        end
        if (op_r == OP_REMOVE && hit) begin
          state_nxt   = ST_SHIFT;
          cmp_vld_nxt = 1'b0;
          wr_idx_nxt  = cmp_idx_r;
          rd_idx_nxt  = cmp_idx_r + CW'(2);
        end else if (!cmp_vld_r && rd_idx_r >= cnt_r) begin
          // scan finished without an early exit
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
          fill_nxt   = cnt_r;
          if (op_r == OP_QUERY) begin
            res_match_nxt = match_r;
            present_nxt   = (match_r != '0);
          end else begin
            ok_nxt = 1'b0;
          end
        end
      end

      ST_SHIFT: begin
        // ram read data holds the entry just above the write slot
        if (wr_idx_r + 1'b1 < cnt_r) begin
          ram_we     = 1'b1;
          ram_waddr  = wr_idx_r[IW-1:0];
          ram_wdata  = ram_rdata;
          wr_idx_nxt = wr_idx_r + 1'b1;
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else begin
          state_nxt  = ST_IDLE;
          strobe_nxt = 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
          fill_nxt   = cnt_r - 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign match_ext = {{COUNT_W{1'b0}}, res_match_r};
  assign fill_ext  = {{COUNT_W{1'b0}}, fill_r};

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = strobe_r;
  assign out_ok          = ok_r;
  assign out_match_count = match_ext[COUNT_W-1:0];
  assign out_present     = present_r;
  assign out_fill_count  = fill_ext[COUNT_W-1:0];
  assign out_is_empty    = (fill_r == '0);

  `MBT_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CW'(CAPACITY))
  `MBT_ASSERT_NEXT(a_start_reacts, start && !busy, busy || out_strobe)
  `MBT_ASSERT_SAME(a_shift_in_range, state_r == ST_SHIFT, wr_idx_r < cnt_r)

endmodule

`default_nettype wire
